[rtl/mexp_pkg.sv]
package mexp_pkg;

    localparam int OPERAND_BITS  = 32;
    localparam int EXPONENT_BITS = 32;
    localparam int RESULT_BITS   = 32;
    localparam int DIV_CNT_BITS  = $clog2(OPERAND_BITS);

    typedef struct packed {
        logic [OPERAND_BITS-1:0]  base_value;
        logic [EXPONENT_BITS-1:0] exponent;
        logic [OPERAND_BITS-1:0]  modulus;
    } mexp_in_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] result;
        logic                   error;
    } mexp_out_t;

endpackage

[rtl/mexp_mulmod.sv]
// Iterative (a * b) mod m by shift-and-add, one multiplier bit per cycle.
// Expects a, b < m. done pulses one cycle; product is held until next start.
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] a,
    input  logic [OPERAND_BITS-1:0] b,
    input  logic [OPERAND_BITS-1:0] m,
    output logic                    done,
    output logic [OPERAND_BITS-1:0] product
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [OPERAND_BITS-1:0] a_reg;
    logic [OPERAND_BITS-1:0] b_reg;
    logic [OPERAND_BITS-1:0] acc_reg;
    logic [OPERAND_BITS-1:0] m_reg;

    logic [OPERAND_BITS-1:0] acc_sum;
    logic [OPERAND_BITS-1:0] a_dbl;

    // (x + y) mod m without overflow, for x, y < m
    function automatic logic [OPERAND_BITS-1:0] add_mod(
        input logic [OPERAND_BITS-1:0] x,
        input logic [OPERAND_BITS-1:0] y,
        input logic [OPERAND_BITS-1:0] md
    );
        logic [OPERAND_BITS-1:0] gap;
        begin
            gap = md - y;
            if (x >= gap)
            begin
                add_mod = x - gap;
            end
            else
            begin
                add_mod = x + y;
            end
        end
    endfunction

    assign acc_sum = add_mod(acc_reg, a_reg, m_reg);
    assign a_dbl   = add_mod(a_reg, a_reg, m_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_sum;
            end
            a_reg <= a_dbl;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/modular_exponentiation_top.sv]
// Sequence: reduction of the base modulo the modulus, then per exponent bit up to the
// highest set one: a check, a squaring and, for a set bit, an accumulator multiply,
// each run by the shared modular multiplier over the bits of its second operand.
// Throughput: one transaction at a time; the shared modular multiplier sets the rate.
// A zero modulus jumps to ST_FINISH with error set. Reset clears state_reg and out_valid.
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mexp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mexp_out_t out_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;  // base % modulus, restoring, 1 bit/cycle
    localparam logic [2:0] ST_CHECK  = 3'd2;  // test exponent, launch next multiply or finish
    localparam logic [2:0] ST_MULA   = 3'd3;  // acc = acc * base mod m
    localparam logic [2:0] ST_SQR    = 3'd4;  // base = base * base mod m
    localparam logic [2:0] ST_FINISH = 3'd5;  // hand result to output register

    logic [2:0]               state_reg,     state_next;
    logic [OPERAND_BITS-1:0]  base_reg,      base_next;
    logic [EXPONENT_BITS-1:0] exp_reg,       exp_next;
    logic [OPERAND_BITS-1:0]  mod_reg,       mod_next;
    logic [OPERAND_BITS-1:0]  acc_reg,       acc_next;
    logic [OPERAND_BITS-1:0]  rem_reg,       rem_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg,       cnt_next;
    logic                     err_reg,       err_next;
    logic                     out_valid_reg, out_valid_next;
    mexp_out_t                out_data_reg,  out_data_next;

    // Division step
    logic [OPERAND_BITS:0]    div_shift;
    logic [OPERAND_BITS-1:0]  div_rem;

    // Shared multiplier hookup
    logic                     mul_start;
    logic [OPERAND_BITS-1:0]  mul_a;
    logic                     mul_done;
    logic [OPERAND_BITS-1:0]  mul_product;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (base_reg),
        .m       (mod_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // Shift the next dividend bit into the partial remainder, subtract if it fits.
    assign div_shift = {rem_reg, base_reg[OPERAND_BITS-1]};
    always_comb
    begin
        if (div_shift >= {1'b0, mod_reg})
        begin
            div_rem = OPERAND_BITS'(div_shift - {1'b0, mod_reg});
        end
        else
        begin
            div_rem = OPERAND_BITS'(div_shift);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        mul_a          = base_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = in_data.base_value;
                    exp_next  = in_data.exponent;
                    mod_next  = in_data.modulus;
                    acc_next  = OPERAND_BITS'(1);
                    rem_next  = '0;
                    cnt_next  = DIV_CNT_BITS'(OPERAND_BITS - 1);
                    err_next  = (in_data.modulus == '0);
                    state_next = (in_data.modulus == '0) ? ST_FINISH : ST_REDUCE;
                end
            end

            ST_REDUCE:
            begin
                base_next = base_reg << 1;
                rem_next  = div_rem;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // base now holds the reduced base
                    base_next  = div_rem;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mul_a      = acc_reg;
                    mul_start  = 1'b1;
                    state_next = ST_MULA;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
            end

            ST_MULA:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_product;
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
            end

            ST_SQR:
            begin
                if (mul_done)
                begin
                    base_next  = mul_product;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_CHECK;
                end
            end

            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.result = err_reg ? '0 : RESULT_BITS'(acc_reg);
                    out_data_next.error  = err_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        mod_reg      <= mod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

endmodule
